// ===== hdl/srtt_pkg.sv =====
// Shared widths, register indexes and the tie-list request type for the
// bounded simplex ratio test. No dependencies.
package srtt_pkg;

    // Field widths of the row and result items.
    localparam int ROW_W      = 10;
    localparam int DATA_W     = 32;
    localparam int DIST_W     = 33;
    localparam int RATIO_W    = 31;
    localparam int FRAC_W     = 16;
    localparam int TOL_W      = 16;

    // Tie entries hold {is_structural, row_number}.
    localparam int ENTRY_W    = ROW_W + 1;
    localparam int STRUCT_BIT = ROW_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AT_UPPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 2'd2;
    localparam logic [TOL_W-1:0]     TOL_RESET    = 16'd1;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W  = 144;
    localparam int M_TDATA_W  = 48;

    // Default depth of the tie list.
    localparam int MAX_TIES_DEF = 16;

    // Requests from the row sequencer to the tie list.
    typedef struct packed {
        logic               clear;
        logic               restart;
        logic               append;
        logic               finish;
        logic [ENTRY_W-1:0] entry;
        logic [DATA_W-1:0]  step;
    } t_tie_cmd;

endpackage

// ===== hdl/simplex_ratio_test_with_ties.sv =====
// Top level of the bounded simplex ratio test: configuration registers,
// row sequencer and the stream ports. Depends on srtt_pkg, srtt_div, srtt_ties.
//
// Usage: one column is sent as a run of basis rows on the slave stream, the
// final row marked with tlast. Each row request is one accepted beat; tuser
// carries is_structural. Configuration is written through i_cfg_we,
// i_cfg_index and i_cfg_data between columns.
// Per row the block accepts the beat, prepares the coefficient magnitude
// and the distance to the chosen bound, and compares the magnitude with the
// tolerance. Above it, the shared radix-2 divider checks for saturation, forms
// the 31-bit ratio bit by bit and registers it, and the minimum is updated; a
// row within the tolerance is skipped. s_axis_tready is low meanwhile.
// After the last row the tie list is partitioned through its memory ports
// (each scanned entry is read and checked, each swap is written back), then
// one result request per tie leaves on the master stream, structural rows
// first; with no tie a single bound-flip result is sent.
// A stalled receiver holds the result in the output register and the
// block takes no further row until the column's last result is accepted.
// Reset (synchronous, active low) clears control state and loads the
// register reset values; the tie memory needs no clearing.
module simplex_ratio_test_with_ties #(
    parameter int MAX_TIES = srtt_pkg::MAX_TIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [srtt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [srtt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Row stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: row_number[9:0], coefficient[41:10], basic_value[73:42],
    //        lower_limit[105:74], upper_limit[137:106], zero[143:138]
    input  logic [srtt_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: is_structural[0]
    input  logic [0:0]                        s_axis_tuser,
    input  logic                              s_axis_tlast,
    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: pivot_row[9:0], step_length[41:10], zero[47:42]
    output logic [srtt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // tuser: bound_flip[0]
    output logic [0:0]                        m_axis_tuser,
    output logic                              m_axis_tlast
);

    localparam int DW = srtt_pkg::DATA_W;
    localparam int RW = srtt_pkg::ROW_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PREP  = 6'b000010,
        S_START = 6'b000100,
        S_DIV   = 6'b001000,
        S_UPD   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state                          r_state, n_state;
    logic [srtt_pkg::RATIO_W-1:0]    r_range;
    logic                            r_at_upper;
    logic [srtt_pkg::TOL_W-1:0]      r_tol;
    logic                            r_in_col, n_in_col;
    logic [DW-1:0]                   r_best, n_best;

    logic [RW-1:0]                   r_row;
    logic                            r_struct;
    logic                            r_last;
    logic signed [DW-1:0]            r_coef, r_basic, r_lower, r_upper;
    logic [DW-1:0]                   r_cmag;
    logic signed [srtt_pkg::DIST_W-1:0] r_dist;

    logic                            w_accept;
    logic                            w_to_upper;
    logic                            w_coef_pos;
    logic                            w_skip;
    logic [srtt_pkg::DIST_W-1:0]     w_dmag;
    logic                            w_div_start;
    logic                            w_div_done;
    logic [srtt_pkg::RATIO_W-1:0]    w_div_ratio;
    logic [DW-1:0]                   w_ratio;
    logic                            w_ties_busy;
    logic [RW-1:0]                   w_pivot_row;
    logic [DW-1:0]                   w_out_step;
    logic [DW-1:0]                   w_step;
    srtt_pkg::t_tie_cmd              w_cmd;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range    <= '0;
            r_at_upper <= 1'b0;
            r_tol      <= srtt_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                srtt_pkg::CFG_RANGE:    r_range    <= i_cfg_data;
                srtt_pkg::CFG_AT_UPPER: r_at_upper <= i_cfg_data[0];
                srtt_pkg::CFG_TOL:      r_tol      <= i_cfg_data[srtt_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !w_ties_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Capture the row request.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row    <= s_axis_tdata[RW-1:0];
            r_coef   <= s_axis_tdata[RW +: DW];
            r_basic  <= s_axis_tdata[RW + DW +: DW];
            r_lower  <= s_axis_tdata[RW + 2*DW +: DW];
            r_upper  <= s_axis_tdata[RW + 3*DW +: DW];
            r_struct <= s_axis_tuser[0];
            r_last   <= s_axis_tlast;
        end
    end

    // Distance to the chosen bound and the coefficient magnitude.
    assign w_coef_pos = !r_coef[DW-1] && (r_coef != '0);
    assign w_to_upper = w_coef_pos != r_at_upper;

    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) begin
            r_cmag <= r_coef[DW-1] ? (DW'(0) - r_coef) : r_coef;
            if (w_to_upper) begin
                r_dist <= {r_upper[DW-1], r_upper} - {r_basic[DW-1], r_basic};
            end else begin
                r_dist <= {r_lower[DW-1], r_lower} - {r_basic[DW-1], r_basic};
            end
        end
    end

    assign w_skip      = r_cmag <= {{(DW - srtt_pkg::TOL_W){1'b0}}, r_tol};
    assign w_dmag      = r_dist[srtt_pkg::DIST_W-1] ? (srtt_pkg::DIST_W'(0) - r_dist)
                                                    : r_dist;
    assign w_div_start = (r_state == S_START) && !w_skip;
    assign w_ratio     = {1'b0, w_div_ratio};
    assign w_step      = r_at_upper ? (DW'(0) - r_best) : r_best;

    // Row sequencer.
    always_comb begin
        n_state       = r_state;
        n_in_col      = r_in_col;
        n_best        = r_best;
        w_cmd         = '0;
        w_cmd.entry   = {r_struct, r_row};
        w_cmd.step    = w_step;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // The first row of a column reloads the minimum.
                    if (!r_in_col) begin
                        n_best    = {1'b0, r_range};
                        n_in_col  = 1'b1;
                        w_cmd.clear = 1'b1;
                    end
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_START;
            end
            S_START: begin
                if (w_skip) begin
                    n_state = r_last ? S_FIN : S_IDLE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                // A smaller ratio restarts the list; an equal one joins it.
                if (w_ratio < r_best) begin
                    n_best        = w_ratio;
                    w_cmd.restart = 1'b1;
                end else if (w_ratio == r_best) begin
                    w_cmd.append = 1'b1;
                end
                n_state = r_last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                w_cmd.finish = 1'b1;
                n_in_col     = 1'b0;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_col <= 1'b0;
            r_best   <= '0;
        end else begin
            r_state  <= n_state;
            r_in_col <= n_in_col;
            r_best   <= n_best;
        end
    end

    srtt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_dmag  (w_dmag),
        .i_cmag  (r_cmag),
        .o_done  (w_div_done),
        .o_ratio (w_div_ratio)
    );

    srtt_ties #(
        .MAX_TIES (MAX_TIES)
    ) u_ties (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_busy       (w_ties_busy),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_pivot_row  (w_pivot_row),
        .o_step       (w_out_step),
        .o_bound_flip (m_axis_tuser[0]),
        .o_last       (m_axis_tlast)
    );

    // Result payload, padded with zeros to whole bytes.
    assign m_axis_tdata = {{(srtt_pkg::M_TDATA_W - RW - DW){1'b0}}, w_out_step, w_pivot_row};

endmodule

// ===== hdl/srtt_div.sv =====
// Shared radix-2 divider for the row ratio: floor(dmag * 2^16 / cmag),
// saturated to 31 bits. Depends on srtt_pkg.
module srtt_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [srtt_pkg::DIST_W-1:0]   i_dmag,
    input  logic [srtt_pkg::DATA_W-1:0]   i_cmag,
    output logic                          o_done,
    output logic [srtt_pkg::RATIO_W-1:0]  o_ratio
);

    localparam int HI_W  = srtt_pkg::DIST_W - srtt_pkg::RATIO_W + srtt_pkg::FRAC_W;
    localparam int LOW_W = srtt_pkg::RATIO_W - srtt_pkg::FRAC_W;
    localparam int CNT_W = $clog2(srtt_pkg::RATIO_W);

    typedef enum logic [2:0] {
        D_IDLE  = 3'b001,
        D_CHECK = 3'b010,
        D_ITER  = 3'b100
    } t_dstate;

    t_dstate                        r_state, n_state;
    logic [HI_W-1:0]                r_hi, n_hi;
    logic [srtt_pkg::RATIO_W-1:0]   r_lo, n_lo;
    logic [srtt_pkg::DATA_W-1:0]    r_den, n_den;
    logic [srtt_pkg::DATA_W-1:0]    r_rem, n_rem;
    logic [srtt_pkg::RATIO_W-1:0]   r_q, n_q;
    logic [CNT_W-1:0]               r_cnt, n_cnt;
    logic                           r_done, n_done;

    logic [srtt_pkg::DATA_W:0]      w_rem2;
    logic [srtt_pkg::DATA_W:0]      w_diff;
    logic [srtt_pkg::DATA_W-1:0]    w_hi_ext;

    assign w_hi_ext = {{(srtt_pkg::DATA_W - HI_W){1'b0}}, r_hi};
    assign w_rem2   = {r_rem, r_lo[srtt_pkg::RATIO_W-1]};
    assign w_diff   = w_rem2 - {1'b0, r_den};

    // One quotient bit per cycle after a saturation check.
    always_comb begin
        n_state = r_state;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_den   = r_den;
        n_rem   = r_rem;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_hi    = i_dmag[srtt_pkg::DIST_W-1:LOW_W];
                    n_lo    = {i_dmag[LOW_W-1:0], {srtt_pkg::FRAC_W{1'b0}}};
                    n_den   = i_cmag;
                    n_state = D_CHECK;
                end
            end
            D_CHECK: begin
                // The quotient overflows 31 bits when the top part already
                // reaches the divisor.
                if (w_hi_ext >= r_den) begin
                    n_q     = {srtt_pkg::RATIO_W{1'b1}};
                    n_done  = 1'b1;
                    n_state = D_IDLE;
                end else begin
                    n_rem   = w_hi_ext;
                    n_cnt   = CNT_W'(srtt_pkg::RATIO_W - 1);
                    n_state = D_ITER;
                end
            end
            D_ITER: begin
                if (!w_diff[srtt_pkg::DATA_W]) begin
                    n_rem = w_diff[srtt_pkg::DATA_W-1:0];
                    n_q   = {r_q[srtt_pkg::RATIO_W-2:0], 1'b1};
                end else begin
                    n_rem = w_rem2[srtt_pkg::DATA_W-1:0];
                    n_q   = {r_q[srtt_pkg::RATIO_W-2:0], 1'b0};
                end
                n_lo = {r_lo[srtt_pkg::RATIO_W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = D_IDLE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_den <= n_den;
        r_rem <= n_rem;
        r_q   <= n_q;
    end

    assign o_done  = r_done;
    assign o_ratio = r_q;

endmodule

// ===== hdl/srtt_ties.sv =====
// Tie list memory with its partition pass and result emission.
// Depends on srtt_pkg.
module srtt_ties #(
    parameter int MAX_TIES = srtt_pkg::MAX_TIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srtt_pkg::t_tie_cmd            i_cmd,
    output logic                          o_busy,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [srtt_pkg::ROW_W-1:0]    o_pivot_row,
    output logic [srtt_pkg::DATA_W-1:0]   o_step,
    output logic                          o_bound_flip,
    output logic                          o_last
);

    localparam int IW = (MAX_TIES > 1) ? $clog2(MAX_TIES) : 1;
    localparam int CW = $clog2(MAX_TIES + 2);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TIES);

    typedef enum logic [7:0] {
        T_IDLE     = 8'b00000001,
        T_SCAN_RD  = 8'b00000010,
        T_SCAN_CK  = 8'b00000100,
        T_LOOP_RD  = 8'b00001000,
        T_LOOP_CK  = 8'b00010000,
        T_SWAP_WR  = 8'b00100000,
        T_EMIT_RD  = 8'b01000000,
        T_EMIT_OUT = 8'b10000000
    } t_tstate;

    logic [srtt_pkg::ENTRY_W-1:0] mem [MAX_TIES];

    t_tstate                       r_state, n_state;
    logic [CW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_b, n_b;
    logic [CW-1:0]                 r_e, n_e;
    logic                          r_valid, n_valid;
    logic                          r_flip, n_flip;
    logic                          r_last, n_last;
    logic [srtt_pkg::DATA_W-1:0]   r_step, n_step;
    logic [srtt_pkg::ENTRY_W-1:0]  r_rd_a, r_rd_b;

    logic                          w_we, w_re_a, w_re_b;
    logic [IW-1:0]                 w_waddr, w_raddr_a, w_raddr_b;
    logic [srtt_pkg::ENTRY_W-1:0]  w_wdata;

    // One write and two registered reads per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re_a) begin
            r_rd_a <= mem[w_raddr_a];
        end
        if (w_re_b) begin
            r_rd_b <= mem[w_raddr_b];
        end
    end

    // Sequencer: collect ties, partition structural rows to the front, emit.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_b       = r_b;
        n_e       = r_e;
        n_valid   = r_valid;
        n_flip    = r_flip;
        n_last    = r_last;
        n_step    = r_step;
        w_we      = 1'b0;
        w_waddr   = r_count[IW-1:0];
        w_wdata   = i_cmd.entry;
        w_re_a    = 1'b0;
        w_re_b    = 1'b0;
        w_raddr_a = r_b[IW-1:0];
        w_raddr_b = r_b[IW-1:0];
        unique case (r_state)
            T_IDLE: begin
                priority if (i_cmd.clear) begin
                    n_count = '0;
                end else if (i_cmd.restart) begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    n_count = CW'(1);
                end else if (i_cmd.append) begin
                    // A tie beyond the list depth is dropped.
                    if (r_count < MAX_CNT) begin
                        w_we    = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end else if (i_cmd.finish) begin
                    n_step = i_cmd.step;
                    if (r_count == '0) begin
                        n_valid = 1'b1;
                        n_flip  = 1'b1;
                        n_last  = 1'b1;
                        n_state = T_EMIT_OUT;
                    end else begin
                        n_b     = '0;
                        n_state = T_SCAN_RD;
                    end
                end
            end
            T_SCAN_RD: begin
                if (r_b < r_count) begin
                    w_re_a  = 1'b1;
                    n_state = T_SCAN_CK;
                end else begin
                    n_e     = r_b + CW'(1);
                    n_state = T_LOOP_RD;
                end
            end
            T_SCAN_CK: begin
                // Extend the leading run of structural ties.
                if (r_rd_a[srtt_pkg::STRUCT_BIT]) begin
                    n_b     = r_b + CW'(1);
                    n_state = T_SCAN_RD;
                end else begin
                    n_e     = r_b + CW'(1);
                    n_state = T_LOOP_RD;
                end
            end
            T_LOOP_RD: begin
                if (r_e < r_count) begin
                    w_re_a    = 1'b1;
                    w_re_b    = 1'b1;
                    w_raddr_a = r_e[IW-1:0];
                    n_state   = T_LOOP_CK;
                end else begin
                    n_e     = '0;
                    n_state = T_EMIT_RD;
                end
            end
            T_LOOP_CK: begin
                // A structural tie trades places with the boundary entry.
                if (r_rd_a[srtt_pkg::STRUCT_BIT]) begin
                    w_we    = 1'b1;
                    w_waddr = r_e[IW-1:0];
                    w_wdata = r_rd_b;
                    n_state = T_SWAP_WR;
                end else begin
                    n_e     = r_e + CW'(1);
                    n_state = T_LOOP_RD;
                end
            end
            T_SWAP_WR: begin
                w_we    = 1'b1;
                w_waddr = r_b[IW-1:0];
                w_wdata = r_rd_a;
                n_b     = r_b + CW'(1);
                n_e     = r_e + CW'(1);
                n_state = T_LOOP_RD;
            end
            T_EMIT_RD: begin
                w_re_a    = 1'b1;
                w_raddr_a = r_e[IW-1:0];
                n_valid   = 1'b1;
                n_flip    = 1'b0;
                n_last    = (r_e + CW'(1)) == r_count;
                n_state   = T_EMIT_OUT;
            end
            T_EMIT_OUT: begin
                if (i_ready) begin
                    n_valid = 1'b0;
                    if (r_last) begin
                        n_state = T_IDLE;
                    end else begin
                        n_e     = r_e + CW'(1);
                        n_state = T_EMIT_RD;
                    end
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_count <= '0;
            r_b     <= '0;
            r_e     <= '0;
            r_valid <= 1'b0;
            r_flip  <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_b     <= n_b;
            r_e     <= n_e;
            r_valid <= n_valid;
            r_flip  <= n_flip;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
    end

    assign o_busy       = (r_state != T_IDLE);
    assign o_valid      = r_valid;
    assign o_pivot_row  = r_flip ? '0 : r_rd_a[srtt_pkg::ROW_W-1:0];
    assign o_step       = r_step;
    assign o_bound_flip = r_flip;
    assign o_last       = r_last;

endmodule
